FILE: rtl/hgm_pkg.sv
// shared types, constants and the depth table of the heightmap mesh generator
// no dependencies; imported by the top level, hgm_front and hgm_back
package hgm_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_SIZE_W = 11;
    localparam int RST_SIZE   = 256;
    localparam logic [15:0] RST_STEP = 16'd256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    localparam int TEX_ONE = 65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_X_STEP      = 3'd2,
        CFG_Y_STEP      = 3'd3,
        CFG_U_STEP      = 3'd4,
        CFG_V_STEP      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] x_step;
        logic [15:0] y_step;
        logic [15:0] u_step;
        logic [15:0] v_step;
    } t_steps;

    // heights of the four quad corners plus end-of-mesh flag
    typedef struct packed {
        logic [7:0] h_ul;
        logic [7:0] h_up;
        logic [7:0] h_lf;
        logic [7:0] h_cur;
        logic       last_of_mesh;
    } t_corners;

    typedef struct packed {
        logic signed [39:0] pos_x;
        logic signed [39:0] pos_y;
        logic        [19:0] pos_z;
        logic signed [47:0] norm_x;
        logic signed [47:0] norm_y;
        logic signed [47:0] norm_z;
        logic        [16:0] tex_u;
        logic        [16:0] tex_v;
        logic               last_of_quad;
        logic               last_of_mesh;
    } t_vertex;

    typedef logic [255:0][19:0] t_depth_tab;

    // 15 - h/51 in Q.16, rounded to nearest; evaluated at elaboration
    function automatic t_depth_tab build_depth_tab();
        t_depth_tab t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 20'(983040 - (i * 65536 + 25) / 51);
        end
        return t;
    endfunction

    localparam t_depth_tab DEPTH_TAB = build_depth_tab();

endpackage

FILE: rtl/heightmap_grid_mesh_generator_top.sv
// top level of the heightmap mesh generator: config registers, front, queues, back
// depends on hgm_pkg, hgm_fifo, hgm_front and hgm_back
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   samples   | i_push / o_full      | i_height
//   vertices  | o_empty / i_pop      | o_pos_*, o_norm_*, o_tex_*, o_last_of_*
//   config    | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// a sample in row 0 or column 0 gives no vertex
// a sample that closes a quad gives six vertices, one per cycle from the back sequencer
// while the result queue has room; its first vertex reaches that queue through front
// stage 2, the quad queue and back stages a, b and c
// reset is synchronous and empties both queues; the line store is not cleared
// front and back stall independently through a four-entry quad queue
module heightmap_grid_mesh_generator_top #(
    parameter int MAX_WIDTH  = hgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hgm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [7:0]                        i_height,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic signed [39:0]                o_pos_x,
    output logic signed [39:0]                o_pos_y,
    output logic [19:0]                       o_pos_z,
    output logic signed [47:0]                o_norm_x,
    output logic signed [47:0]                o_norm_y,
    output logic signed [47:0]                o_norm_z,
    output logic [16:0]                       o_tex_u,
    output logic [16:0]                       o_tex_v,
    output logic                              o_last_of_quad,
    output logic                              o_last_of_mesh,
    input  logic                              i_cfg_we,
    input  logic [hgm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hgm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hgm_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SW  = $clog2(MAX_WIDTH + 1);
    localparam int SH  = $clog2(MAX_HEIGHT + 1);
    localparam int CMW = (SW > SH) ? ((SW > CFG_SIZE_W) ? SW : CFG_SIZE_W)
                                   : ((SH > CFG_SIZE_W) ? SH : CFG_SIZE_W);
    localparam int RST_W = (RST_SIZE > MAX_WIDTH) ? MAX_WIDTH : RST_SIZE;
    localparam int RST_H = (RST_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RST_SIZE;
    localparam int QW  = $bits(t_corners) + CW + RW;
    localparam int VW  = $bits(t_vertex);

    logic [SW-1:0]  r_w;
    logic [SH-1:0]  r_h;
    t_steps         r_steps;
    logic           restart;

    logic           q_push, q_pop, q_full, q_empty;
    logic [QCNT_W-1:0] q_count;
    t_corners       q_in_corners, q_out_corners;
    logic [CW-1:0]  q_in_col, q_out_col;
    logic [RW-1:0]  q_in_row, q_out_row;
    logic [QW-1:0]  q_out_data;

    logic           vtx_push, vtx_full;
    t_vertex        vtx_in, vtx_out;
    logic [VW-1:0]  vtx_out_data;
    logic [OCNT_W-1:0] vtx_count;

    function automatic logic [CMW-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] v,
                                                  input logic [CMW-1:0] top);
        logic [CMW-1:0] e;
        e = CMW'(v);
        if (e < CMW'(2)) return CMW'(2);
        if (e > top)     return top;
        return e;
    endfunction

    assign restart = i_cfg_we && ((i_cfg_idx == CFG_GRID_WIDTH) ||
                                  (i_cfg_idx == CFG_GRID_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= SW'(RST_W);
            r_h     <= SH'(RST_H);
            r_steps <= '{x_step: RST_STEP, y_step: RST_STEP,
                         u_step: RST_STEP, v_step: RST_STEP};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:
                    r_w <= SW'(clamp_size(i_cfg_data[CFG_SIZE_W-1:0], CMW'(MAX_WIDTH)));
                CFG_GRID_HEIGHT:
                    r_h <= SH'(clamp_size(i_cfg_data[CFG_SIZE_W-1:0], CMW'(MAX_HEIGHT)));
                CFG_X_STEP: r_steps.x_step <= i_cfg_data;
                CFG_Y_STEP: r_steps.y_step <= i_cfg_data;
                CFG_U_STEP: r_steps.u_step <= i_cfg_data;
                CFG_V_STEP: r_steps.v_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hgm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_w         (r_w),
        .i_h         (r_h),
        .i_restart   (restart),
        .i_push      (i_push),
        .i_height    (i_height),
        .o_full      (o_full),
        .i_q_count   (q_count),
        .o_q_push    (q_push),
        .o_q_corners (q_in_corners),
        .o_q_col     (q_in_col),
        .o_q_row     (q_in_row)
    );

    hgm_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_quad_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({q_in_corners, q_in_col, q_in_row}),
        .i_pop   (q_pop),
        .o_data  (q_out_data),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign {q_out_corners, q_out_col, q_out_row} = q_out_data;

    hgm_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_w         (r_w),
        .i_h         (r_h),
        .i_steps     (r_steps),
        .i_q_empty   (q_empty || q_full && 1'b0),
        .o_q_pop     (q_pop),
        .i_q_corners (q_out_corners),
        .i_q_col     (q_out_col),
        .i_q_row     (q_out_row),
        .o_vtx_push  (vtx_push),
        .i_vtx_full  (vtx_full),
        .o_vtx       (vtx_in)
    );

    hgm_fifo #(.WIDTH(VW), .DEPTH(OUT_DEPTH)) u_vtx_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (vtx_push),
        .i_data  (vtx_in),
        .i_pop   (i_pop),
        .o_data  (vtx_out_data),
        .o_full  (vtx_full),
        .o_empty (o_empty),
        .o_count (vtx_count)
    );

    assign vtx_out = t_vertex'(vtx_out_data);

    assign o_pos_x        = vtx_out.pos_x;
    assign o_pos_y        = vtx_out.pos_y;
    assign o_pos_z        = vtx_out.pos_z;
    assign o_norm_x       = vtx_out.norm_x;
    assign o_norm_y       = vtx_out.norm_y;
    assign o_norm_z       = vtx_out.norm_z;
    assign o_tex_u        = vtx_out.tex_u;
    assign o_tex_v        = vtx_out.tex_v;
    assign o_last_of_quad = vtx_out.last_of_quad;
    // held low while the result queue is empty
    assign o_last_of_mesh = vtx_out.last_of_mesh && (vtx_count != '0);

endmodule

FILE: rtl/hgm_fifo.sv
// small first-in first-out queue of register entries
// depends on nothing; used between front and back and on the result side
module hgm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [WIDTH-1:0]                 i_data,
    input  logic                             i_pop,
    output logic [WIDTH-1:0]                 o_data,
    output logic                             o_full,
    output logic                             o_empty,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNW-1:0]   r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= next_ptr(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= next_ptr(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (!do_push && do_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

FILE: rtl/hgm_front.sv
// front part: raster counters, previous-row line store and quad detection
// depends on hgm_pkg; feeds closed quads into the front-to-back queue
module hgm_front #(
    parameter int MAX_WIDTH  = hgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hgm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_h,
    input  logic                              i_restart,
    input  logic                              i_push,
    input  logic [7:0]                        i_height,
    output logic                              o_full,
    input  logic [hgm_pkg::QCNT_W-1:0]        i_q_count,
    output logic                              o_q_push,
    output hgm_pkg::t_corners                 o_q_corners,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_q_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]     o_q_row
);
    import hgm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SW = $clog2(MAX_WIDTH + 1);
    localparam int SH = $clog2(MAX_HEIGHT + 1);

    logic [7:0]    r_mem [MAX_WIDTH];
    logic [7:0]    r_up;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [7:0]    r_lf, r_ul;

    logic          r_s2_valid;
    logic [7:0]    r_s2_h, r_s2_lf;
    logic [CW-1:0] r_s2_col;
    logic [RW-1:0] r_s2_row;
    logic          r_s2_quad, r_s2_lm;

    logic          accept, last_col, last_row;
    logic [SW-1:0] w_m1;
    logic [SH-1:0] h_m1;

    // count a beat in stage 2 as already queued so it never finds the queue full
    assign o_full   = ({1'b0, i_q_count} + (QCNT_W+1)'(r_s2_valid)) >= (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept   = i_push && !o_full;
    assign w_m1     = i_w - 1'b1;
    assign h_m1     = i_h - 1'b1;
    assign last_col = (r_col == CW'(w_m1));
    assign last_row = (r_row == RW'(h_m1));

    // line store: old entry is read while the new height replaces it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_col] <= i_height;
            r_up         <= r_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_lf       <= '0;
            r_ul       <= '0;
            r_s2_valid <= 1'b0;
        end else if (i_restart) begin
            r_col      <= '0;
            r_row      <= '0;
            r_lf       <= '0;
            r_ul       <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= accept;
            if (r_s2_valid) r_ul <= r_up;
            if (accept) begin
                r_lf <= i_height;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                    if (last_row) r_lf <= '0;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_h    <= i_height;
            r_s2_lf   <= r_lf;
            r_s2_col  <= r_col;
            r_s2_row  <= r_row;
            r_s2_quad <= (r_col != '0) && (r_row != '0);
            r_s2_lm   <= last_col && last_row;
        end
    end

    assign o_q_push = r_s2_valid && r_s2_quad;
    assign o_q_corners = '{h_ul: r_ul, h_up: r_up, h_lf: r_s2_lf, h_cur: r_s2_h,
                           last_of_mesh: r_s2_lm};
    assign o_q_col = r_s2_col;
    assign o_q_row = r_s2_row;

endmodule

FILE: rtl/hgm_back.sv
// back part: quad arithmetic pipeline and six-vertex sequencer
// depends on hgm_pkg; pops quads from the queue, pushes vertices to the result queue
module hgm_back #(
    parameter int MAX_WIDTH  = hgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hgm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_h,
    input  hgm_pkg::t_steps                   i_steps,
    input  logic                              i_q_empty,
    output logic                              o_q_pop,
    input  hgm_pkg::t_corners                 i_q_corners,
    input  logic [$clog2(MAX_WIDTH)-1:0]      i_q_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]     i_q_row,
    output logic                              o_vtx_push,
    input  logic                              i_vtx_full,
    output hgm_pkg::t_vertex                  o_vtx
);
    import hgm_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SW  = $clog2(MAX_WIDTH + 1);
    localparam int SH  = $clog2(MAX_HEIGHT + 1);
    localparam int DXW = SW + 2;
    localparam int DYW = SH + 2;
    localparam int PXW = DXW + 17;
    localparam int PYW = DYW + 17;
    localparam int ZDW = 21;
    localparam int NPW = ZDW + 17;
    localparam int TUW = CW + 16;
    localparam int TVW = RW + 16;
    localparam int TMW = ((CW > RW) ? CW : RW) + 16;
    localparam logic [2:0] VTX_LAST = 3'd5;

    // stage a: depths, differences and signed offsets
    logic                  r_a_valid;
    logic [19:0]           r_a_z1, r_a_z2, r_a_z3, r_a_z4;
    logic signed [ZDW-1:0] r_a_d21, r_a_d13, r_a_d43, r_a_d24;
    logic signed [DXW-1:0] r_a_dx0, r_a_dx1;
    logic signed [DYW-1:0] r_a_dy0, r_a_dy1;
    logic [CW-1:0]         r_a_c0, r_a_c1;
    logic [RW-1:0]         r_a_r0, r_a_r1;
    logic                  r_a_lm;

    // stage b: products
    logic                  r_b_valid;
    logic [19:0]           r_b_z1, r_b_z2, r_b_z3, r_b_z4;
    logic signed [PXW-1:0] r_b_px0, r_b_px1;
    logic signed [PYW-1:0] r_b_py0, r_b_py1;
    logic signed [NPW-1:0] r_b_ax, r_b_ay, r_b_bx, r_b_by;
    logic [31:0]           r_b_nz;
    logic [TUW-1:0]        r_b_tu0, r_b_tu1;
    logic [TVW-1:0]        r_b_tv0, r_b_tv1;
    logic                  r_b_lm;

    // stage c: finished quad, held while its six vertices go out
    logic                  r_c_valid;
    logic [19:0]           r_c_z1, r_c_z2, r_c_z3, r_c_z4;
    logic signed [39:0]    r_c_px0, r_c_px1, r_c_py0, r_c_py1;
    logic signed [47:0]    r_c_ax, r_c_ay, r_c_bx, r_c_by, r_c_nz;
    logic [16:0]           r_c_tu0, r_c_tu1, r_c_tv0, r_c_tv1;
    logic                  r_c_lm;
    logic [2:0]            r_vidx;

    logic [CW-1:0] col_m1;
    logic [RW-1:0] row_m1;
    logic [19:0]   z1, z2, z3, z4;
    logic          vtx_fire, c_done, c_take, b_move, b_take, a_move, a_take;
    logic          sel_col, sel_row;

    function automatic logic signed [47:0] round8(input logic signed [NPW-1:0] p);
        logic signed [NPW-1:0] q;
        q = p + $signed(NPW'(128));
        return 48'(q >>> 8);
    endfunction

    function automatic logic [16:0] sat_tex(input logic [TMW-1:0] t);
        return (t > TMW'(TEX_ONE)) ? 17'(TEX_ONE) : 17'(t);
    endfunction

    assign vtx_fire = r_c_valid && !i_vtx_full;
    assign c_done   = vtx_fire && (r_vidx == VTX_LAST);
    assign c_take   = !r_c_valid || c_done;
    assign b_move   = r_b_valid && c_take;
    assign b_take   = !r_b_valid || b_move;
    assign a_move   = r_a_valid && b_take;
    assign a_take   = !r_a_valid || a_move;
    assign o_q_pop  = !i_q_empty && a_take;

    assign col_m1 = i_q_col - 1'b1;
    assign row_m1 = i_q_row - 1'b1;
    assign z1 = DEPTH_TAB[i_q_corners.h_ul];
    assign z2 = DEPTH_TAB[i_q_corners.h_up];
    assign z3 = DEPTH_TAB[i_q_corners.h_lf];
    assign z4 = DEPTH_TAB[i_q_corners.h_cur];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_vidx    <= '0;
        end else begin
            if (a_take) r_a_valid <= o_q_pop;
            if (b_take) r_b_valid <= a_move;
            if (c_take) r_c_valid <= b_move;
            if (vtx_fire) r_vidx <= (r_vidx == VTX_LAST) ? '0 : r_vidx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_z1  <= z1;
            r_a_z2  <= z2;
            r_a_z3  <= z3;
            r_a_z4  <= z4;
            r_a_d21 <= ZDW'(z2) - ZDW'(z1);
            r_a_d13 <= ZDW'(z1) - ZDW'(z3);
            r_a_d43 <= ZDW'(z4) - ZDW'(z3);
            r_a_d24 <= ZDW'(z2) - ZDW'(z4);
            r_a_dx0 <= DXW'({col_m1, 1'b0}) - DXW'(i_w);
            r_a_dx1 <= DXW'({i_q_col, 1'b0}) - DXW'(i_w);
            r_a_dy0 <= DYW'(i_h) - DYW'({row_m1, 1'b0});
            r_a_dy1 <= DYW'(i_h) - DYW'({i_q_row, 1'b0});
            r_a_c0  <= col_m1;
            r_a_c1  <= i_q_col;
            r_a_r0  <= row_m1;
            r_a_r1  <= i_q_row;
            r_a_lm  <= i_q_corners.last_of_mesh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_z1  <= r_a_z1;
            r_b_z2  <= r_a_z2;
            r_b_z3  <= r_a_z3;
            r_b_z4  <= r_a_z4;
            r_b_px0 <= r_a_dx0 * $signed({1'b0, i_steps.x_step});
            r_b_px1 <= r_a_dx1 * $signed({1'b0, i_steps.x_step});
            r_b_py0 <= r_a_dy0 * $signed({1'b0, i_steps.y_step});
            r_b_py1 <= r_a_dy1 * $signed({1'b0, i_steps.y_step});
            r_b_ax  <= $signed({1'b0, i_steps.y_step}) * r_a_d21;
            r_b_ay  <= $signed({1'b0, i_steps.x_step}) * r_a_d13;
            r_b_bx  <= $signed({1'b0, i_steps.y_step}) * r_a_d43;
            r_b_by  <= $signed({1'b0, i_steps.x_step}) * r_a_d24;
            r_b_nz  <= i_steps.x_step * i_steps.y_step;
            r_b_tu0 <= r_a_c0 * i_steps.u_step;
            r_b_tu1 <= r_a_c1 * i_steps.u_step;
            r_b_tv0 <= r_a_r0 * i_steps.v_step;
            r_b_tv1 <= r_a_r1 * i_steps.v_step;
            r_b_lm  <= r_a_lm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_c_z1  <= r_b_z1;
            r_c_z2  <= r_b_z2;
            r_c_z3  <= r_b_z3;
            r_c_z4  <= r_b_z4;
            r_c_px0 <= 40'(r_b_px0) <<< 7;
            r_c_px1 <= 40'(r_b_px1) <<< 7;
            r_c_py0 <= 40'(r_b_py0) <<< 7;
            r_c_py1 <= 40'(r_b_py1) <<< 7;
            r_c_ax  <= round8(r_b_ax);
            r_c_ay  <= round8(r_b_ay);
            r_c_bx  <= round8(r_b_bx);
            r_c_by  <= round8(r_b_by);
            r_c_nz  <= -$signed(48'(r_b_nz));
            r_c_tu0 <= sat_tex(TMW'(r_b_tu0));
            r_c_tu1 <= sat_tex(TMW'(r_b_tu1));
            r_c_tv0 <= sat_tex(TMW'(r_b_tv0));
            r_c_tv1 <= sat_tex(TMW'(r_b_tv1));
            r_c_lm  <= r_b_lm;
        end
    end

    // corner order: upper-left, upper-right, lower-left, lower-right, lower-left, upper-right
    always_comb begin
        unique case (r_vidx)
            3'd0:    begin sel_col = 1'b0; sel_row = 1'b0; end
            3'd1:    begin sel_col = 1'b1; sel_row = 1'b0; end
            3'd2:    begin sel_col = 1'b0; sel_row = 1'b1; end
            3'd3:    begin sel_col = 1'b1; sel_row = 1'b1; end
            3'd4:    begin sel_col = 1'b0; sel_row = 1'b1; end
            3'd5:    begin sel_col = 1'b1; sel_row = 1'b0; end
            default: begin sel_col = 1'b0; sel_row = 1'b0; end
        endcase
    end

    always_comb begin
        o_vtx.pos_x = sel_col ? r_c_px1 : r_c_px0;
        o_vtx.pos_y = sel_row ? r_c_py1 : r_c_py0;
        unique case ({sel_row, sel_col})
            2'b00: o_vtx.pos_z = r_c_z1;
            2'b01: o_vtx.pos_z = r_c_z2;
            2'b10: o_vtx.pos_z = r_c_z3;
            2'b11: o_vtx.pos_z = r_c_z4;
            default: o_vtx.pos_z = r_c_z1;
        endcase
        // second triangle from the fourth vertex on
        o_vtx.norm_x       = (r_vidx >= 3'd3) ? r_c_bx : r_c_ax;
        o_vtx.norm_y       = (r_vidx >= 3'd3) ? r_c_by : r_c_ay;
        o_vtx.norm_z       = r_c_nz;
        o_vtx.tex_u        = sel_col ? r_c_tu1 : r_c_tu0;
        o_vtx.tex_v        = sel_row ? r_c_tv1 : r_c_tv0;
        o_vtx.last_of_quad = (r_vidx == VTX_LAST);
        o_vtx.last_of_mesh = (r_vidx == VTX_LAST) && r_c_lm;
    end

    assign o_vtx_push = vtx_fire;

endmodule

FILE: rtl/hgm_checker.sv
// port-level checks on the heightmap mesh generator, bound to the top level
// depends on nothing but the top level's ports
module hgm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_push,
    input logic                o_full,
    input logic [7:0]          i_height,
    input logic                o_empty,
    input logic                i_pop,
    input logic signed [39:0]  o_pos_x,
    input logic signed [39:0]  o_pos_y,
    input logic [19:0]         o_pos_z,
    input logic signed [47:0]  o_norm_x,
    input logic signed [47:0]  o_norm_y,
    input logic signed [47:0]  o_norm_z,
    input logic [16:0]         o_tex_u,
    input logic [16:0]         o_tex_v,
    input logic                o_last_of_quad,
    input logic                o_last_of_mesh,
    input logic                i_cfg_we,
    input logic [2:0]          i_cfg_idx,
    input logic [15:0]         i_cfg_data
);

    // end of mesh only ever marks the closing vertex of a quad
    a_mesh_end_on_quad_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_last_of_mesh) |-> o_last_of_quad)
        else $error("last_of_mesh without last_of_quad");

    // depth stays between 10 and 15 in Q.16
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_pos_z >= 20'd655360) && (o_pos_z <= 20'd983040))
        else $error("vertex depth out of range");

    // texture coordinates saturate at one
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_tex_u <= 17'd65536) && (o_tex_v <= 17'd65536))
        else $error("texture coordinate above one");

    // a waiting beat holds until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_pos_x) && $stable(o_norm_z)
                                  && $stable(o_last_of_quad)))
        else $error("waiting result changed before pop");

endmodule

bind heightmap_grid_mesh_generator_top hgm_checker u_hgm_checker (.*);
